FILE: rtl/core/sorted_insert_list_unit_assert.svh
// Assertion macros for the sorted insert list RTL.
`ifndef SORTED_INSERT_LIST_UNIT_ASSERT_SVH
`define SORTED_INSERT_LIST_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SIL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SIL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sil_pkg.sv
// Package: sizes, codes and cell control types of the sorted insert list.
package sil_pkg;

  localparam int CAPACITY  = 32;
  localparam int KEY_WIDTH = 24;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef logic signed [KEY_WIDTH-1:0] key_t;
  typedef logic [CNT_W-1:0]            count_t;

  typedef enum logic [1:0] {
    MODE_INSERT    = 2'd0,
    MODE_READ_ASC  = 2'd1,
    MODE_READ_DESC = 2'd2,
    MODE_NONE      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RSVD  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD      = 2'd0,
    OP_INSERT    = 2'd1,
    OP_ROT_LEFT  = 2'd2,
    OP_ROT_RIGHT = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    key_t     key;
  } cell_ctl_t;

endpackage

FILE: rtl/core/sil_if.sv
// Interfaces: request and response channels of the sorted insert list.
interface sil_req_if;
  import sil_pkg::*;
  logic  valid;
  logic  ready;
  logic [1:0] mode;
  key_t  key_value;

  modport source (output valid, output mode, output key_value, input ready);
  modport sink (input valid, input mode, input key_value, output ready);
endinterface

interface sil_rsp_if;
  import sil_pkg::*;
  logic  valid;
  logic  ready;
  key_t  out_value;
  logic  is_last;
  logic [1:0] status;

  modport source (output valid, output out_value, output is_last, output status,
                  input ready);
  modport sink (input valid, input out_value, input is_last, input status,
                output ready);
endinterface

FILE: rtl/core/sorted_insert_list_unit.sv
// Top level: sorted insert list built as a chain of key cells.
//
//  channel | dir | payload                      | accepted when
//  --------+-----+------------------------------+------------------------
//  req     | in  | mode, key_value              | req.valid && req.ready
//  rsp     | out | out_value, is_last, status   | rsp.valid && rsp.ready
//
//  Insert: all cells compare in parallel and shift right behind the
//    insertion point. The status transaction waits in the output register.
//  Read: the request starts the readout, then one result per cycle while
//    the output register is free; the chain rotates once per result and is
//    back in order after the last one.
//  req.ready is low while a read streams or the output register is stalled.
//  Synchronous reset clears the valid bits, the count and the output valid.
module sorted_insert_list_unit (
  input logic      clk,
  input logic      rst,
  sil_req_if.sink  req,
  sil_rsp_if.source rsp
);
  import sil_pkg::*;
  `include "sorted_insert_list_unit_assert.svh"

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t    state, state_next;
  count_t    count, count_next;
  count_t    remain, remain_next;
  logic      descend, descend_next;

  logic      out_valid, out_valid_next;
  key_t      out_value, out_value_next;
  logic      out_last, out_last_next;
  status_t   out_status, out_status_next;

  cell_ctl_t cell_ctl;
  key_t      cell_value [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_take;
  logic [CAPACITY-1:0] tail_vec;
  key_t      left_value [CAPACITY];
  logic [CAPACITY-1:0] left_valid;
  logic [CAPACITY-1:0] left_take;
  key_t      right_value [CAPACITY];
  logic [CAPACITY-1:0] right_valid;
  key_t      tail_value;

  logic      out_free;
  logic      req_fire;

  assign out_free = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign req_fire = req.valid && req.ready;

  // Tail cell: the last valid one. Its key wraps to cell 0 on a right rotate.
  assign tail_vec = cell_valid & ~(cell_valid >> 1);

  always_comb begin
    tail_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_value = tail_value | (cell_value[i] & {KEY_WIDTH{tail_vec[i]}});
    end
  end

  // Neighbor wiring: cell 0 gets the tail from its left, the last cell
  // sees no right neighbor and wraps to cell 0.
  always_comb begin
    left_value[0] = tail_value;
    left_valid[0] = 1'b1;
    left_take[0]  = 1'b0;
    for (int i = 1; i < CAPACITY; i++) begin
      left_value[i] = cell_value[i-1];
      left_valid[i] = cell_valid[i-1];
      left_take[i]  = cell_take[i-1];
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      right_value[i] = cell_value[i+1];
      right_valid[i] = cell_valid[i+1];
    end
    right_value[CAPACITY-1] = cell_value[0];
    right_valid[CAPACITY-1] = 1'b0;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    sil_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (cell_ctl),
      .left_value  (left_value[g]),
      .left_valid  (left_valid[g]),
      .left_take   (left_take[g]),
      .right_value (right_value[g]),
      .right_valid (right_valid[g]),
      .wrap_value  (cell_value[0]),
      .value       (cell_value[g]),
      .valid       (cell_valid[g]),
      .take        (cell_take[g])
    );
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    remain_next     = remain;
    descend_next    = descend;
    out_valid_next  = out_valid && !rsp.ready;
    out_value_next  = out_value;
    out_last_next   = out_last;
    out_status_next = out_status;
    cell_ctl.op     = OP_HOLD;
    cell_ctl.key    = req.key_value;

    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          case (mode_t'(req.mode))
            MODE_INSERT: begin
              out_valid_next = 1'b1;
              out_value_next = '0;
              out_last_next  = 1'b1;
              if (count == CNT_W'(CAPACITY)) begin
                // Full: drop the key, report it.
                out_status_next = STATUS_FULL;
              end else begin
                cell_ctl.op     = OP_INSERT;
                count_next      = count + 1'b1;
                out_status_next = STATUS_OK;
              end
            end
            MODE_READ_ASC, MODE_READ_DESC: begin
              if (count == '0) begin
                out_valid_next  = 1'b1;
                out_value_next  = '0;
                out_last_next   = 1'b1;
                out_status_next = STATUS_EMPTY;
              end else begin
                state_next   = ST_READ;
                remain_next  = count;
                descend_next = (mode_t'(req.mode) == MODE_READ_DESC);
              end
            end
            default: begin
              // Unused mode: drop the transaction without a result.
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          // Emit the head (ascending) or tail (descending), then rotate.
          out_valid_next  = 1'b1;
          out_value_next  = descend ? tail_value : cell_value[0];
          out_last_next   = (remain == CNT_W'(1));
          out_status_next = STATUS_OK;
          cell_ctl.op     = descend ? OP_ROT_RIGHT : OP_ROT_LEFT;
          remain_next     = remain - 1'b1;
          if (remain == CNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    remain     <= remain_next;
    descend    <= descend_next;
    out_value  <= out_value_next;
    out_last   <= out_last_next;
    out_status <= out_status_next;
  end

  assign rsp.valid     = out_valid;
  assign rsp.out_value = out_value;
  assign rsp.is_last   = out_last;
  assign rsp.status    = out_status;

  `SIL_ASSERT_NOW(a_count_matches_cells, clk, rst, 1'b1,
    $countones(cell_valid) == 32'(count), "valid cells disagree with count")
  `SIL_ASSERT_NOW(a_count_bounded, clk, rst, 1'b1,
    count <= CNT_W'(CAPACITY), "count beyond capacity")
  `SIL_ASSERT_NOW(a_no_accept_while_reading, clk, rst, state == ST_READ,
    !req.ready, "request taken during readout")
  `SIL_ASSERT_NEXT(a_insert_grows, clk, rst,
    req_fire && req.mode == MODE_INSERT && count != CNT_W'(CAPACITY),
    count == $past(count) + 1'b1, "insert did not grow the count")

endmodule

FILE: rtl/core/sil_cell.sv
// One cell of the sorted key chain: a key, its valid bit and neighbor moves.
module sil_cell (
  input  logic             clk,
  input  logic             rst,
  input  sil_pkg::cell_ctl_t ctl,
  input  sil_pkg::key_t    left_value,
  input  logic             left_valid,
  input  logic             left_take,
  input  sil_pkg::key_t    right_value,
  input  logic             right_valid,
  input  sil_pkg::key_t    wrap_value,
  output sil_pkg::key_t    value,
  output logic             valid,
  output logic             take
);
  import sil_pkg::*;

  // At or past the insertion point: empty, or holding a key >= the new one.
  always_comb take = !valid || (value >= ctl.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.op == OP_INSERT) begin
      if (left_take) begin
        valid <= left_valid;
      end else if (take) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_INSERT: begin
        if (left_take) begin
          value <= left_value;
        end else if (take) begin
          value <= ctl.key;
        end
      end
      OP_ROT_LEFT: begin
        if (valid) begin
          value <= right_valid ? right_value : wrap_value;
        end
      end
      OP_ROT_RIGHT: begin
        if (valid) begin
          value <= left_value;
        end
      end
      default: begin
        value <= value;
      end
    endcase
  end

endmodule

FILE: bench/sorted_insert_list_unit_checker.sv
// Checker: watches both channels, tracks the sorted key store and compares results.
module sorted_insert_list_unit_checker (
  input  logic clk,
  input  logic rst,
  sil_req_if   req,
  sil_rsp_if   rsp,
  output int   fail_count,
  output int   results_due
);
  import sil_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    key_t    value;
    logic    last;
    status_t status;
  } list_result_t;

  key_t         held_keys[$];        // ascending, as the block should hold them
  list_result_t awaited_results[$];  // oldest first

  function automatic list_result_t make_result(key_t value, logic last, status_t status);
    list_result_t res;
    res.value  = value;
    res.last   = last;
    res.status = status;
    return res;
  endfunction

  // Update the key store for one request and queue the results it causes.
  function automatic void project_request(mode_t mode, key_t key);
    int   n;
    int   pos;
    int   i;
    key_t picked;
    n   = held_keys.size();
    pos = n;
    case (mode)
      MODE_INSERT: begin
        if (n >= CAPACITY) begin
          awaited_results.push_back(make_result('0, 1'b1, STATUS_FULL));
        end else begin
          // new key lands in front of the first stored key that is >= it
          for (i = 0; i < n; i++) begin
            if (held_keys[i] >= key) begin
              pos = i;
              break;
            end
          end
          held_keys.insert(pos, key);
          awaited_results.push_back(make_result('0, 1'b1, STATUS_OK));
        end
      end
      MODE_READ_ASC, MODE_READ_DESC: begin
        if (n == 0) begin
          awaited_results.push_back(make_result('0, 1'b1, STATUS_EMPTY));
        end else begin
          for (i = 0; i < n; i++) begin
            picked = (mode == MODE_READ_ASC) ? held_keys[i] : held_keys[n-1-i];
            awaited_results.push_back(make_result(picked, i == n - 1, STATUS_OK));
          end
        end
      end
      default: ;  // no operation behind this code
    endcase
  endfunction

  function automatic void compare_result(key_t value, logic last, logic [1:0] status);
    list_result_t want;
    if (awaited_results.size() == 0) begin
      $error("result with none awaited: out_value=%0d is_last=%0b status=%0d",
             value, last, status);
      fail_count++;
    end else begin
      want = awaited_results.pop_front();
      if (value !== want.value) begin
        $error("out_value mismatch: expected %0d, actual %0d", want.value, value);
        fail_count++;
      end
      if (last !== want.last) begin
        $error("is_last mismatch: expected %0b, actual %0b", want.last, last);
        fail_count++;
      end
      if (status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, status);
        fail_count++;
      end
    end
  endfunction

  // Check the result first: it can only stem from an earlier request.
  always @(posedge clk) begin
    if (rst) begin
      fail_count  = 0;
      results_due = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        compare_result(rsp.out_value, rsp.is_last, rsp.status);
      end
      if (req.valid && req.ready) begin
        project_request(mode_t'(req.mode), req.key_value);
      end
      results_due = awaited_results.size();
    end
  end

endmodule

FILE: bench/sorted_insert_list_unit_tb.sv
// Testbench top: clock, reset, request and response drivers, watchdog and verdict.
module sorted_insert_list_unit_tb;
  import sil_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET     = 320;   // accepted requests with an operation
  localparam int RSP_HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int QUIET_LIMIT     = 4000;  // cycles without any transaction
  localparam int TAIL_CYCLES     = 40;

  logic clk;
  logic rst;
  int   fail_count;
  int   results_due;

  // Handshake between the request driver and the response sink.
  bit   hold_rsp;
  bit   req_steady;
  int   items_sent;
  int   inserts_sent;
  key_t used_keys[$];

  sil_req_if req_ch();
  sil_rsp_if rsp_ch();

  sorted_insert_list_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sorted_insert_list_unit_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_gap();
    return req_steady ? 0 : idle_len();
  endfunction

  // Key mix: full-range values, a narrow band near zero that forces equal
  // keys, and repeats of keys already sent.
  function automatic key_t pick_key();
    case ($urandom_range(0, 3))
      0, 1: return key_t'($urandom);
      2: return key_t'(int'($urandom_range(0, 15)) - 8);
      default: begin
        if (used_keys.size() == 0) begin
          return '0;
        end
        return used_keys[$urandom_range(0, used_keys.size() - 1)];
      end
    endcase
  endfunction

  // Offer one request after an optional gap and hold it until accepted.
  // Valid stays high after acceptance so back-to-back transactions need
  // only one assignment per falling edge.
  task automatic send_request(mode_t mode, key_t key, int gap);
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid     <= 1'b1;
    req_ch.mode      <= mode;
    req_ch.key_value <= key;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    if (mode != MODE_NONE) begin
      items_sent++;
    end
    if (mode == MODE_INSERT) begin
      inserts_sent++;
      used_keys.push_back(key);
    end
  endtask

  // Drop valid and wait until every expected result has been seen.
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    wait (results_due == 0);
  endtask

  // Response sink: random stalls, stretches at full rate, and one long
  // hold-off on request from the stimulus, counted here.
  initial begin : response_sink
    int  stall_left;
    int  span;
    bit  steady;
    stall_left = 0;
    span       = 0;
    steady     = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES - 1) @(negedge clk);
        hold_rsp = 1'b0;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) begin
          stall_left = idle_len();
        end
      end
      span++;
      if (span == 64) begin
        span   = 0;
        steady = ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int  roll;
    bit  mid_drained;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.mode      = MODE_INSERT;
    req_ch.key_value = '0;
    hold_rsp         = 1'b0;
    req_steady       = 1'b0;
    items_sent       = 0;
    inserts_sent     = 0;
    mid_drained      = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reads of the empty store, an ignored code, extreme and
    // equal keys, then reads both ways.
    send_request(MODE_READ_ASC, '0, 0);
    send_request(MODE_READ_DESC, '1, 1);
    send_request(MODE_NONE, '1, 0);
    send_request(MODE_INSERT, 24'sh7FFFFF, 0);
    send_request(MODE_INSERT, 24'sh800000, 0);
    send_request(MODE_INSERT, 24'sh000000, 2);
    send_request(MODE_INSERT, 24'sh000000, 0);
    send_request(MODE_INSERT, 24'shFFFFFF, 0);
    send_request(MODE_INSERT, 24'sh000100, 1);
    send_request(MODE_INSERT, 24'sh555555, 0);
    send_request(MODE_INSERT, 24'shAAAAAA, 0);
    send_request(MODE_READ_ASC, '0, 0);
    send_request(MODE_READ_DESC, '0, 0);
    send_request(MODE_INSERT, 24'sh7FFFFF, 0);
    send_request(MODE_INSERT, 24'sh800000, 0);
    send_request(MODE_READ_ASC, '0, 3);
    wait_drained();

    // Fill the store. Hold the receiver back first so the output register
    // stalls while inserts keep coming and the request side backs up.
    hold_rsp = 1'b1;
    while (inserts_sent < CAPACITY) begin
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
        send_request(roll < 10 ? MODE_READ_ASC : MODE_READ_DESC, key_t'($urandom),
                     pick_gap());
      end else if (roll < 25) begin
        send_request(MODE_NONE, key_t'($urandom), pick_gap());
      end else begin
        send_request(MODE_INSERT, pick_key(), pick_gap());
      end
      if ($urandom_range(0, 9) == 0) begin
        req_steady = !req_steady;
      end
    end
    wait_drained();

    // Store is full: full-length reads both ways, dropped inserts and
    // ignored codes as noise.
    while (items_sent < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        send_request(roll < 22 ? MODE_READ_ASC : MODE_READ_DESC, key_t'($urandom),
                     pick_gap());
      end else if (roll < 90) begin
        send_request(MODE_INSERT, pick_key(), pick_gap());
      end else begin
        send_request(MODE_NONE, key_t'($urandom), pick_gap());
      end
      if ($urandom_range(0, 19) == 0) begin
        req_steady = !req_steady;
      end
      if (!mid_drained && items_sent >= 200) begin
        mid_drained = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
